@@ sv/wto_pkg.sv @@
package wto_pkg;

    localparam int PHASE_W = 32;   // phase is an unsigned fraction of one cycle
    localparam int FRAC_W  = 16;   // interpolation weight below the entry index
    localparam int LEN_W   = 11;   // table length register
    localparam int INDEX_W = 10;   // write index field
    localparam int LEN_RESET = 1024;

    typedef enum logic [1:0] {
        ACT_WRITE    = 2'd0,
        ACT_GENERATE = 2'd1,
        ACT_LOOKUP   = 2'd2,
        ACT_NONE     = 2'd3
    } t_action;

endpackage

@@ sv/wto_mul.sv @@
module wto_mul
    import wto_pkg::*;
#(
    parameter int A_W = PHASE_W + 1,
    parameter int B_W = FRAC_W + 1
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [A_W-1:0]      i_a,
    input  logic signed [B_W-1:0]      i_b,
    output logic signed [A_W+B_W-1:0]  o_p
);

    logic signed [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

@@ sv/wto_table.sv @@
module wto_table #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/wavetable_oscillator_interp_unit.sv @@
// Wavetable oscillator with linear interpolation. A write word (action 0) stores one signed
// sample into the table if its index is below TABLE_DEPTH; action 3 is dropped. Neither
// lowers o_ready. A generate word (action 1) reads at the phase accumulator and then adds
// phase_step; a lookup word (action 2) reads at phase_value. After a reading word is
// accepted, o_ready stays low through S_MUL1, S_RD1, S_RD2, S_MUL2 and S_FIN, and the
// sample is loaded into the output register as S_FIN is left, once o_valid is low or
// i_ready is high. The one shared multiplier is used twice (phase times length, then
// difference times weight) and the table's single read port is used twice (both
// neighboring entries). table_length is written over the cfg channel, saturates to the
// range 2 to TABLE_DEPTH, and resets to 1024 (or TABLE_DEPTH if smaller). Table entries
// must be written before they are read; the table has no reset.
module wavetable_oscillator_interp_unit
    import wto_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_action,
    input  logic [INDEX_W-1:0]            i_table_index,
    input  logic signed [SAMPLE_BITS-1:0] i_table_value,
    input  logic [PHASE_W-1:0]            i_phase_step,
    input  logic [PHASE_W-1:0]            i_phase_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [LEN_W-1:0]              i_cfg_data
);

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int A_W     = PHASE_W + 1;
    localparam int B_W     = FRAC_W + 1;
    localparam int P_W     = A_W + B_W;
    localparam int D_W     = SAMPLE_BITS + 1;
    localparam int LEN_RST = (TABLE_DEPTH < LEN_RESET) ? TABLE_DEPTH : LEN_RESET;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL1 = 6'b000010,
        S_RD1  = 6'b000100,
        S_RD2  = 6'b001000,
        S_MUL2 = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [PHASE_W-1:0]      r_acc;
    logic [LEN_W-1:0]        r_len;
    logic [PHASE_W-1:0]      r_phase;
    logic [FRAC_W-1:0]       r_t;
    logic [LEN_W-1:0]        r_i2;
    logic [SAMPLE_BITS-1:0]  r_v1;
    logic                    r_out_valid;
    logic [SAMPLE_BITS-1:0]  r_sample;

    logic                    w_accept;
    logic                    w_read_item;
    logic                    w_we;
    logic                    w_re;
    logic [ADDR_W-1:0]       w_raddr;
    logic [SAMPLE_BITS-1:0]  w_rdata;
    logic                    w_mul_en;
    logic signed [A_W-1:0]   w_mul_a;
    logic signed [B_W-1:0]   w_mul_b;
    logic signed [P_W-1:0]   w_prod;
    logic [LEN_W-1:0]        w_i1;
    logic [LEN_W-1:0]        w_i1_inc;
    logic signed [D_W-1:0]   w_diff;
    logic signed [P_W-1:0]   w_shift;
    logic [SAMPLE_BITS-1:0]  w_interp;
    logic                    w_fin_go;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && o_ready;
    assign w_read_item = (i_action == ACT_GENERATE) || (i_action == ACT_LOOKUP);
    assign w_we        = w_accept && (i_action == ACT_WRITE) &&
                         (int'(i_table_index) < TABLE_DEPTH);

    // entry index and weight come straight out of phase times length
    assign w_i1     = w_prod[PHASE_W +: LEN_W];
    assign w_i1_inc = w_i1 + LEN_W'(1);

    assign w_re    = (r_state == S_RD1) || (r_state == S_RD2);
    assign w_raddr = (r_state == S_RD1) ? ADDR_W'(w_i1) : ADDR_W'(r_i2);

    assign w_diff   = D_W'($signed(w_rdata)) - D_W'($signed(r_v1));
    assign w_shift  = w_prod >>> FRAC_W;
    assign w_interp = w_shift[SAMPLE_BITS-1:0] + r_v1;
    assign w_fin_go = (r_state == S_FIN) && (!r_out_valid || i_ready);

    always_comb begin
        w_mul_en = 1'b0;
        w_mul_a  = $signed({1'b0, r_phase});
        w_mul_b  = $signed(B_W'(r_len));
        unique case (r_state)
            S_MUL1: begin
                w_mul_en = 1'b1;
            end
            S_MUL2: begin
                w_mul_en = 1'b1;
                w_mul_a  = A_W'(w_diff);
                w_mul_b  = $signed({1'b0, r_t});
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_read_item) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_MUL2;
            S_MUL2: n_state = S_FIN;
            S_FIN: begin
                if (w_fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_len       <= LEN_W'(LEN_RST);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && (i_action == ACT_GENERATE)) begin
                r_acc <= r_acc + i_phase_step;
            end
            if (i_cfg_valid) begin
                if (i_cfg_data < LEN_W'(2)) begin
                    r_len <= LEN_W'(2);
                end else if (int'(i_cfg_data) > TABLE_DEPTH) begin
                    r_len <= LEN_W'(TABLE_DEPTH);
                end else begin
                    r_len <= i_cfg_data;
                end
            end
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_phase <= (i_action == ACT_GENERATE) ? r_acc : i_phase_value;
        end
        if (r_state == S_RD1) begin
            r_t  <= w_prod[FRAC_W +: FRAC_W];
            r_i2 <= (w_i1_inc == r_len) ? '0 : w_i1_inc;
        end
        // first neighbor arrives while the second is being read
        if (r_state == S_RD2) begin
            r_v1 <= w_rdata;
        end
        if (w_fin_go) begin
            r_sample <= w_interp;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sample = r_sample;

    wto_table #(
        .DEPTH  (TABLE_DEPTH),
        .DATA_W (SAMPLE_BITS),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (ADDR_W'(i_table_index)),
        .i_wdata (i_table_value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    wto_mul #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len >= LEN_W'(2)) && (int'(r_len) <= TABLE_DEPTH))
        else $error("table length out of range");

    a_index_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD1) |-> (w_i1 < r_len))
        else $error("entry index beyond table length");

    a_read_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_read_item) |=> (r_state == S_MUL1))
        else $error("reading word did not start the sequence");

    a_acc_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_action == ACT_GENERATE)) |=>
            (r_acc == $past(r_acc + i_phase_step)))
        else $error("phase accumulator did not advance");

endmodule
